[hw/rtl/ctpc_pkg.sv]
// ----------------------------------------------------------------------------
// ctpc_pkg: shared types and constants
// Lane geometry, compact word fields, order and reason codes for the
// compact target proof-of-work check.
// ----------------------------------------------------------------------------
package ctpc_pkg;

  // slice and lane geometry
  localparam int SLICE_W    = 64;
  localparam int SLICE_CNT  = 4;
  localparam int LANE_W     = 16;
  localparam int LANE_COUNT = SLICE_W / LANE_W;

  // compact word layout
  localparam int COMPACT_W = 32;
  localparam int MANT_W    = 24;
  localparam int EXP_W     = 8;
  localparam int SHIFT_W   = 8;

  // lane window: mantissa padded by one chunk on each side
  localparam int LANE_WIN_W = MANT_W + 2 * LANE_W;

  localparam logic [COMPACT_W-1:0] MANT_MASK   = 32'h00ff_ffff;
  localparam int                   ZERO_OFFSET = 29;
  localparam int                   EXP_BIAS    = 3;
  localparam logic [COMPACT_W-1:0] LIMIT_RESET = 32'h1f00_ffff;

  // running order of hash against target
  typedef enum logic [1:0] {
    ORDER_EQUAL   = 2'd0,
    ORDER_LESS    = 2'd1,
    ORDER_GREATER = 2'd2
  } order_t;

  // reason codes on the result channel
  typedef enum logic [1:0] {
    REASON_PASS  = 2'd0,
    REASON_LIMIT = 2'd1,
    REASON_ABOVE = 2'd2
  } reason_t;

  // decoded compact word: target = mant << shift
  typedef struct packed {
    logic [MANT_W-1:0]  mant;
    logic [SHIFT_W-1:0] shift;
  } target_prep_t;

  // per-lane compare outcome
  typedef struct packed {
    logic lt;
    logic gt;
  } lane_cmp_t;

endpackage

[hw/rtl/compact_target_pow_check.sv]
// ----------------------------------------------------------------------------
// compact_target_pow_check: proof-of-work check against a compact target
// Four lanes compare one 64-bit hash slice per cycle, while not stalled, with
// the target rebuilt from the compact word; the result follows the last slice.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one 64-bit hash slice per
//   transaction, most significant slice first. in_compact_bits is sampled on
//   the first slice of each hash and ignored on the other three.
//   Result channel (out_valid / out_stall) carries one transaction per hash:
//   out_pow_ok and out_fail_reason (0 pass, 1 compact below limit,
//   2 hash above target).
//   cfg_wr_en / cfg_wr_data write the compact limit; write only while idle.
// Throughput: one slice per cycle while in_stall is low. Each slice goes
//   through the four 16-bit compare lanes and the merge combinationally.
// Result: registered, it shows in the cycle after the fourth slice is
//   accepted.
// Stall: a waiting result blocks only a fourth slice; first to third slices
//   are still taken while the receiver stalls.
// Reset: clears the slice count, the order, the held compact word and the
//   output valid, and sets the compact limit to 0x1f00ffff.
// ----------------------------------------------------------------------------
module compact_target_pow_check import ctpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SLICE_W-1:0]   in_hash_word,
  input  logic [COMPACT_W-1:0] in_compact_bits,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_pow_ok,
  output logic [1:0]           out_fail_reason,
  input  logic                 cfg_wr_en,
  input  logic [COMPACT_W-1:0] cfg_wr_data
);

  logic [COMPACT_W-1:0] limit_r;
  logic [1:0]           slice_count_r, slice_count_nxt;
  order_t               order_r, order_nxt;
  logic [COMPACT_W-1:0] held_compact_r, held_compact_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_pow_ok_r, out_pow_ok_nxt;
  reason_t              out_reason_r, out_reason_nxt;

  logic                 in_fire;
  logic                 last_slice;
  logic [COMPACT_W-1:0] cur_compact;
  target_prep_t         prep;
  lane_cmp_t            lane_cmp [LANE_COUNT];
  order_t               slice_order;
  order_t               final_order;

  // handshake
  assign last_slice = slice_count_r == 2'(SLICE_CNT - 1);
  assign in_stall   = out_valid_r && out_stall && last_slice;
  assign in_fire    = in_valid && !in_stall;

  // compact word: live on the first slice, held afterwards
  assign cur_compact = (slice_count_r == '0) ? in_compact_bits : held_compact_r;

  ctpc_prep u_prep (
    .compact (cur_compact),
    .prep    (prep)
  );

  // compare lanes, lane LANE_COUNT-1 holds the top chunk
  for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
    logic [SHIFT_W-1:0] chunk_base;
    assign chunk_base = {~slice_count_r, 6'(i * LANE_W)};

    ctpc_lane u_lane (
      .hash_chunk (in_hash_word[i*LANE_W +: LANE_W]),
      .prep       (prep),
      .chunk_base (chunk_base),
      .cmp        (lane_cmp[i])
    );
  end

  // merge: most significant differing lane decides
  always_comb begin
    slice_order = ORDER_EQUAL;
    for (int j = 0; j < LANE_COUNT; j++) begin
      if (lane_cmp[j].lt) begin
        slice_order = ORDER_LESS;
      end else if (lane_cmp[j].gt) begin
        slice_order = ORDER_GREATER;
      end
    end
  end

  assign final_order = (order_r == ORDER_EQUAL) ? slice_order : order_r;

  // sequencing of slices and order
  always_comb begin
    slice_count_nxt  = slice_count_r;
    order_nxt        = order_r;
    held_compact_nxt = held_compact_r;
    if (in_fire) begin
      held_compact_nxt = cur_compact;
      if (last_slice) begin
        slice_count_nxt = '0;
        order_nxt       = ORDER_EQUAL;
      end else begin
        slice_count_nxt = slice_count_r + 2'd1;
        order_nxt       = final_order;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_pow_ok_nxt = out_pow_ok_r;
    out_reason_nxt = out_reason_r;
    if (in_fire && last_slice) begin
      out_valid_nxt = 1'b1;
      if (cur_compact < limit_r) begin
        out_pow_ok_nxt = 1'b0;
        out_reason_nxt = REASON_LIMIT;
      end else if (final_order == ORDER_GREATER) begin
        out_pow_ok_nxt = 1'b0;
        out_reason_nxt = REASON_ABOVE;
      end else begin
        out_pow_ok_nxt = 1'b1;
        out_reason_nxt = REASON_PASS;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= LIMIT_RESET;
      slice_count_r <= '0;
      order_r       <= ORDER_EQUAL;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      slice_count_r <= slice_count_nxt;
      order_r       <= order_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // held compact resets to zero, result payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_compact_r <= '0;
    end else begin
      held_compact_r <= held_compact_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pow_ok_r <= out_pow_ok_nxt;
    out_reason_r <= out_reason_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pow_ok      = out_pow_ok_r;
  assign out_fail_reason = out_reason_r;

endmodule

[hw/rtl/ctpc_prep.sv]
// ----------------------------------------------------------------------------
// ctpc_prep: compact word decoder
// Splits the compact word into a normalized mantissa and a left shift so
// that the 256-bit target equals mant << shift.
// ----------------------------------------------------------------------------
module ctpc_prep import ctpc_pkg::*; (
  input  logic [COMPACT_W-1:0] compact,
  output target_prep_t         prep
);

  logic [EXP_W-1:0]  exp_f;
  logic [MANT_W-1:0] mant_f;
  logic [4:0]        exp_off;
  logic [1:0]        rshift_bytes;

  assign exp_f        = compact[COMPACT_W-1 -: EXP_W];
  assign mant_f       = MANT_W'(compact & MANT_MASK);
  assign exp_off      = 5'(exp_f - EXP_W'(EXP_BIAS));
  assign rshift_bytes = 2'(EXP_W'(EXP_BIAS) - exp_f);

  // small exponent shifts right, large offset gives a zero target
  always_comb begin
    if (exp_f <= EXP_W'(EXP_BIAS)) begin
      prep.mant  = mant_f >> {rshift_bytes, 3'b000};
      prep.shift = '0;
    end else if (exp_f >= EXP_W'(ZERO_OFFSET + EXP_BIAS)) begin
      prep.mant  = '0;
      prep.shift = '0;
    end else begin
      prep.mant  = mant_f;
      prep.shift = {exp_off, 3'b000};
    end
  end

endmodule

[hw/rtl/ctpc_lane.sv]
// ----------------------------------------------------------------------------
// ctpc_lane: one compare lane
// Builds a 16-bit chunk of the target at a given bit position and compares
// the matching hash chunk against it.
// ----------------------------------------------------------------------------
module ctpc_lane import ctpc_pkg::*; (
  input  logic [LANE_W-1:0]  hash_chunk,
  input  target_prep_t       prep,
  input  logic [SHIFT_W-1:0] chunk_base,
  output lane_cmp_t          cmp
);

  logic signed [9:0]     offset;
  logic signed [9:0]     win_shift;
  logic [LANE_WIN_W-1:0] window;
  logic [LANE_WIN_W-1:0] shifted;
  logic [LANE_W-1:0]     tgt_chunk;
  logic                  in_reach;

  // offset of the mantissa low bit relative to this chunk
  assign offset    = $signed({2'b00, prep.shift}) - $signed({2'b00, chunk_base});
  assign win_shift = 10'sd16 - offset;
  assign in_reach  = (offset >= -10'sd23) && (offset <= 10'sd15);
  assign window    = {{LANE_W{1'b0}}, prep.mant, {LANE_W{1'b0}}};
  assign shifted   = window >> win_shift[5:0];
  assign tgt_chunk = in_reach ? shifted[LANE_W-1:0] : '0;

  // chunk compare
  assign cmp.lt = hash_chunk < tgt_chunk;
  assign cmp.gt = hash_chunk > tgt_chunk;

endmodule
